/* src/rpcda_pkg.sv */
package rpcda_pkg;

    // Pixel word as it arrives on the input channel
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [9:0] column;
        logic [9:0] row;
        logic       last_of_frame;
    } pix_word_t;

    // One result word per frame
    typedef struct packed {
        logic signed [15:0] average_cm;
        logic signed [15:0] frame_distance_cm;
        logic [20:0]        lit_pixel_count;
        logic               window_full;
    } res_word_t;

    // Per-frame status handed from the window store to the mean stage
    typedef struct packed {
        logic signed [15:0] distance;
        logic [20:0]        count;
        logic               full;
    } frame_info_t;

    typedef enum logic [2:0] {
        CFG_LOWER_THR  = 3'd0,
        CFG_UPPER_THR  = 3'd1,
        CFG_ROI_LEFT   = 3'd2,
        CFG_ROI_TOP    = 3'd3,
        CFG_ROI_WIDTH  = 3'd4,
        CFG_ROI_HEIGHT = 3'd5,
        CFG_SLOPE      = 3'd6,
        CFG_INTERCEPT  = 3'd7
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [7:0]         RST_LOWER_THR  = 8'd50;
    localparam logic [7:0]         RST_UPPER_THR  = 8'd255;
    localparam logic [9:0]         RST_ROI_LEFT   = 10'd0;
    localparam logic [9:0]         RST_ROI_TOP    = 10'd100;
    localparam logic [10:0]        RST_ROI_WIDTH  = 11'd352;
    localparam logic [10:0]        RST_ROI_HEIGHT = 11'd300;
    localparam logic signed [20:0] RST_SLOPE      = -21'sd2687;
    localparam logic signed [31:0] RST_INTERCEPT  = 32'sd13998162;

    // Gray conversion, Q14 weights with rounding
    localparam int               GRAY_SUM_W   = 22;
    localparam logic [21:0]      GRAY_W_BLUE  = 22'd1868;
    localparam logic [21:0]      GRAY_W_GREEN = 22'd9617;
    localparam logic [21:0]      GRAY_W_RED   = 22'd4899;
    localparam logic [21:0]      GRAY_ROUND   = 22'd8192;

    localparam int               TALLY_W   = 21;
    localparam logic [20:0]      TALLY_MAX = 21'h1FFFFF;

    localparam int               DIST_W  = 16;
    localparam int               PROD_W  = 43;
    localparam int               Q_W     = 44;
    localparam int               Q_FRAC  = 16;
    localparam logic signed [43:0] Q_ROUND_NEG = 44'sd65535;
    localparam logic signed [43:0] Q_DIST_MAX  = 44'sd32767;
    localparam logic signed [43:0] Q_DIST_MIN  = -44'sd32768;
    localparam logic signed [15:0] DIST_MAX    = 16'sh7FFF;
    localparam logic signed [15:0] DIST_MIN    = -16'sh8000;

    // Result queue
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = 4;
    localparam int FIFO_CNT_W = 5;

endpackage

/* src/rpcda_window.sv */
module rpcda_window
    import rpcda_pkg::*;
#(
    parameter int WINDOW_FRAMES = 30,
    parameter int SUM_W         = 21
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     frame_valid,
    input  logic signed [DIST_W-1:0] distance,
    input  logic [TALLY_W-1:0]       count,
    output logic                     done_valid,
    output frame_info_t              info,
    output logic signed [SUM_W-1:0]  sum
);

    localparam int PTR_W  = $clog2(WINDOW_FRAMES);
    localparam int FILL_W = $clog2(WINDOW_FRAMES + 1);

    logic signed [DIST_W-1:0] mem [WINDOW_FRAMES];

    logic [PTR_W-1:0]         ptr_reg, ptr_next;
    logic [FILL_W-1:0]        fill_reg;
    logic                     evict;

    logic                     w2_valid_reg;
    logic [PTR_W-1:0]         w2_ptr_reg;
    logic signed [DIST_W-1:0] w2_dist_reg;
    logic [TALLY_W-1:0]       w2_count_reg;
    logic                     w2_sub_reg;
    logic                     w2_full_reg;
    logic signed [DIST_W-1:0] old_reg;

    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic                     done_valid_reg;
    frame_info_t              info_reg;

    assign evict    = (fill_reg == FILL_W'(WINDOW_FRAMES));
    assign ptr_next = (ptr_reg == PTR_W'(WINDOW_FRAMES - 1)) ? '0 : ptr_reg + PTR_W'(1);

    // Oldest entry leaves the sum once the window is full
    always_comb
    begin
        sum_next = sum_reg + SUM_W'(w2_dist_reg);
        if (w2_sub_reg)
        begin
            sum_next = sum_next - SUM_W'(old_reg);
        end
    end

    // Window store: read the slot at frame entry, write it in the next cycle
    always_ff @(posedge clk)
    begin
        if (w2_valid_reg)
        begin
            mem[w2_ptr_reg] <= w2_dist_reg;
        end
        if (frame_valid)
        begin
            old_reg      <= mem[ptr_reg];
            w2_ptr_reg   <= ptr_reg;
            w2_dist_reg  <= distance;
            w2_count_reg <= count;
            w2_sub_reg   <= evict;
            w2_full_reg  <= evict || (fill_reg == FILL_W'(WINDOW_FRAMES - 1));
        end
        if (w2_valid_reg)
        begin
            info_reg.distance <= w2_dist_reg;
            info_reg.count    <= w2_count_reg;
            info_reg.full     <= w2_full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            fill_reg       <= '0;
            w2_valid_reg   <= 1'b0;
            sum_reg        <= '0;
            done_valid_reg <= 1'b0;
        end
        else
        begin
            w2_valid_reg   <= frame_valid;
            done_valid_reg <= w2_valid_reg;
            if (frame_valid)
            begin
                ptr_reg <= ptr_next;
                if (!evict)
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end
            if (w2_valid_reg)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    assign done_valid = done_valid_reg;
    assign info       = info_reg;
    assign sum        = sum_reg;

endmodule

/* src/rpcda_res_fifo.sv */
module rpcda_res_fifo
    import rpcda_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  res_word_t push_word,
    output logic      pop_valid,
    input  logic      pop_ready,
    output res_word_t pop_word
);

    res_word_t               mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic                    pop;

    // Space is guaranteed by the credit count upstream
    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_word  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (push_valid && !pop)
            begin
                count_reg <= count_reg + FIFO_CNT_W'(1);
            end
            else if (!push_valid && pop)
            begin
                count_reg <= count_reg - FIFO_CNT_W'(1);
            end
        end
    end

endmodule

/* src/roi_pixel_count_distance_averager_top.sv */
// Region pixel-count distance averager.
// pix channel (pix_valid/pix_ready/pix): one BGR pixel word per cycle while
// pix_ready is high, with column, row and an end-of-frame mark. Pixels in
// the configured rectangle are made gray and counted if in the threshold band.
// res channel (res_valid/res_ready/res): one word per frame, sent after the
// last pixel: frame distance, lit pixel count, mean of the last WINDOW_FRAMES
// distances (0 until the window is full) and the window-full flag.
// cfg port: write cfg_data to register cfg_index while cfg_we is high; write
// only while the block is idle.
// Throughput: one pixel word per cycle while pix_ready is high, frames of any
// length including one pixel. res_valid rises once the last pixel of a frame
// has passed the pipeline (gray, tally, multiply, add, scale, window read,
// window sum, magnitude, mean multiply, queue write), the gray stage loading
// at the edge that takes that pixel.
// Up to FIFO_DEPTH (16) result words may be owed, those still in the pipeline
// included; while that many are owed pix_ready is low. A stalled receiver
// therefore only holds the input back once 16 words are owed. Reset restores
// the register defaults and empties tally, window and queue; no clearing pass
// is needed.
module roi_pixel_count_distance_averager_top
    import rpcda_pkg::*;
#(
    parameter int WINDOW_FRAMES = 30
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pix_valid,
    output logic                  pix_ready,
    input  pix_word_t             pix,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_word_t             res
);

    // Mean by reciprocal multiply: exact floor(n / W) for n below 2^SUM_W
    localparam int SUM_W     = DIST_W + $clog2(WINDOW_FRAMES);
    localparam int DIV_L     = $clog2(WINDOW_FRAMES);
    localparam int DIV_K     = SUM_W + DIV_L;
    localparam int RECIP_W   = SUM_W + 1;
    localparam int DPROD_W   = SUM_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << DIV_K) + 64'(WINDOW_FRAMES) - 64'd1) / 64'(WINDOW_FRAMES);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [7:0]         lower_thr_reg;
    logic [7:0]         upper_thr_reg;
    logic [9:0]         roi_left_reg;
    logic [9:0]         roi_top_reg;
    logic [10:0]        roi_width_reg;
    logic [10:0]        roi_height_reg;
    logic signed [20:0] slope_reg;
    logic signed [31:0] intercept_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_thr_reg  <= RST_LOWER_THR;
            upper_thr_reg  <= RST_UPPER_THR;
            roi_left_reg   <= RST_ROI_LEFT;
            roi_top_reg    <= RST_ROI_TOP;
            roi_width_reg  <= RST_ROI_WIDTH;
            roi_height_reg <= RST_ROI_HEIGHT;
            slope_reg      <= RST_SLOPE;
            intercept_reg  <= RST_INTERCEPT;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LOWER_THR:  lower_thr_reg  <= cfg_data[7:0];
                CFG_UPPER_THR:  upper_thr_reg  <= cfg_data[7:0];
                CFG_ROI_LEFT:   roi_left_reg   <= cfg_data[9:0];
                CFG_ROI_TOP:    roi_top_reg    <= cfg_data[9:0];
                CFG_ROI_WIDTH:  roi_width_reg  <= cfg_data[10:0];
                CFG_ROI_HEIGHT: roi_height_reg <= cfg_data[10:0];
                CFG_SLOPE:      slope_reg      <= $signed(cfg_data[20:0]);
                CFG_INTERCEPT:  intercept_reg  <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Credits: every frame in flight or queued holds one queue slot
    // ---------------------------------------------------------------
    logic                  pix_accept;
    logic                  res_accept;
    logic                  frame_in;
    logic [FIFO_CNT_W-1:0] pending_reg, pending_next;

    assign pix_ready  = (pending_reg < FIFO_CNT_W'(FIFO_DEPTH));
    assign pix_accept = pix_valid && pix_ready;
    assign res_accept = res_valid && res_ready;
    assign frame_in   = pix_accept && pix.last_of_frame;

    always_comb
    begin
        pending_next = pending_reg;
        if (frame_in && !res_accept)
        begin
            pending_next = pending_reg + FIFO_CNT_W'(1);
        end
        else if (!frame_in && res_accept)
        begin
            pending_next = pending_reg - FIFO_CNT_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: rectangle test, gray conversion, band test
    // ---------------------------------------------------------------
    logic [9:0]            col_off;
    logic [9:0]            row_off;
    logic                  in_roi;
    logic [GRAY_SUM_W-1:0] gray_sum;
    logic [7:0]            gray;
    logic                  hit;

    always_comb
    begin
        col_off  = pix.column - roi_left_reg;
        row_off  = pix.row - roi_top_reg;
        in_roi   = (pix.column >= roi_left_reg) && ({1'b0, col_off} < roi_width_reg) &&
                   (pix.row >= roi_top_reg) && ({1'b0, row_off} < roi_height_reg);
        gray_sum = GRAY_W_BLUE * GRAY_SUM_W'(pix.blue) +
                   GRAY_W_GREEN * GRAY_SUM_W'(pix.green) +
                   GRAY_W_RED * GRAY_SUM_W'(pix.red) + GRAY_ROUND;
        gray     = gray_sum[GRAY_SUM_W-1 -: 8];
        hit      = in_roi && (gray >= lower_thr_reg) && (gray <= upper_thr_reg);
    end

    logic hit_valid_reg;
    logic hit_reg;
    logic hit_last_reg;

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            hit_reg      <= hit;
            hit_last_reg <= pix.last_of_frame;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: tally, saturating; frame end hands the count on
    // ---------------------------------------------------------------
    logic [TALLY_W-1:0] tally_reg;
    logic [TALLY_W-1:0] count_now;
    logic               f1_valid_reg;
    logic [TALLY_W-1:0] f1_count_reg;

    assign count_now = (hit_reg && (tally_reg != TALLY_MAX)) ?
                       tally_reg + TALLY_W'(1) : tally_reg;

    // Stages 3 to 5: slope * count, + intercept, truncate and saturate
    logic signed [PROD_W-1:0] prod_reg;
    logic                     f2_valid_reg;
    logic [TALLY_W-1:0]       f2_count_reg;
    logic signed [Q_W-1:0]    q_reg;
    logic                     f3_valid_reg;
    logic [TALLY_W-1:0]       f3_count_reg;
    logic signed [Q_W-1:0]    q_adj;
    logic signed [Q_W-1:0]    q_cm;
    logic signed [DIST_W-1:0] dist_sat;
    logic                     f4_valid_reg;
    logic signed [DIST_W-1:0] f4_dist_reg;
    logic [TALLY_W-1:0]       f4_count_reg;

    // Round toward zero: bias negatives before the arithmetic shift
    always_comb
    begin
        q_adj = q_reg[Q_W-1] ? q_reg + Q_ROUND_NEG : q_reg;
        q_cm  = q_adj >>> Q_FRAC;
        if (q_cm > Q_DIST_MAX)
        begin
            dist_sat = DIST_MAX;
        end
        else if (q_cm < Q_DIST_MIN)
        begin
            dist_sat = DIST_MIN;
        end
        else
        begin
            dist_sat = q_cm[DIST_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_valid_reg && hit_last_reg)
        begin
            f1_count_reg <= count_now;
        end
        if (f1_valid_reg)
        begin
            prod_reg     <= PROD_W'(slope_reg) * PROD_W'($signed({1'b0, f1_count_reg}));
            f2_count_reg <= f1_count_reg;
        end
        if (f2_valid_reg)
        begin
            q_reg        <= Q_W'(prod_reg) + Q_W'(intercept_reg);
            f3_count_reg <= f2_count_reg;
        end
        if (f3_valid_reg)
        begin
            f4_dist_reg  <= dist_sat;
            f4_count_reg <= f3_count_reg;
        end
    end

    // ---------------------------------------------------------------
    // Window store and running sum
    // ---------------------------------------------------------------
    logic                    win_valid;
    frame_info_t             win_info;
    logic signed [SUM_W-1:0] win_sum;

    rpcda_window #(
        .WINDOW_FRAMES (WINDOW_FRAMES),
        .SUM_W         (SUM_W)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (f4_valid_reg),
        .distance    (f4_dist_reg),
        .count       (f4_count_reg),
        .done_valid  (win_valid),
        .info        (win_info),
        .sum         (win_sum)
    );

    // ---------------------------------------------------------------
    // Mean: magnitude, reciprocal multiply, shift and restore sign
    // ---------------------------------------------------------------
    logic                 m1_valid_reg;
    logic                 m1_neg_reg;
    logic [SUM_W-1:0]     m1_mag_reg;
    frame_info_t          m1_info_reg;
    logic                 m2_valid_reg;
    logic                 m2_neg_reg;
    logic [DPROD_W-1:0]   m2_prod_reg;
    frame_info_t          m2_info_reg;
    logic [DPROD_W-1:0]   quot_full;
    logic [SUM_W-1:0]     quot;
    logic signed [SUM_W-1:0] avg_s;
    res_word_t            push_word;

    always_ff @(posedge clk)
    begin
        if (win_valid)
        begin
            m1_neg_reg  <= win_sum[SUM_W-1];
            m1_mag_reg  <= win_sum[SUM_W-1] ? SUM_W'(-win_sum) : SUM_W'(win_sum);
            m1_info_reg <= win_info;
        end
        if (m1_valid_reg)
        begin
            m2_prod_reg <= DPROD_W'(m1_mag_reg) * DPROD_W'(RECIP_W'(RECIP));
            m2_neg_reg  <= m1_neg_reg;
            m2_info_reg <= m1_info_reg;
        end
    end

    always_comb
    begin
        quot_full = m2_prod_reg >> DIV_K;
        quot      = quot_full[SUM_W-1:0];
        avg_s     = m2_neg_reg ? -$signed(quot) : $signed(quot);
        push_word.average_cm        = m2_info_reg.full ? avg_s[DIST_W-1:0] : '0;
        push_word.frame_distance_cm = m2_info_reg.distance;
        push_word.lit_pixel_count   = m2_info_reg.count;
        push_word.window_full       = m2_info_reg.full;
    end

    rpcda_res_fifo u_res_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (m2_valid_reg),
        .push_word  (push_word),
        .pop_valid  (res_valid),
        .pop_ready  (res_ready),
        .pop_word   (res)
    );

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            hit_valid_reg <= 1'b0;
            tally_reg     <= '0;
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            f3_valid_reg  <= 1'b0;
            f4_valid_reg  <= 1'b0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            hit_valid_reg <= pix_accept;
            if (hit_valid_reg)
            begin
                tally_reg <= hit_last_reg ? '0 : count_now;
            end
            f1_valid_reg  <= hit_valid_reg && hit_last_reg;
            f2_valid_reg  <= f1_valid_reg;
            f3_valid_reg  <= f2_valid_reg;
            f4_valid_reg  <= f3_valid_reg;
            m1_valid_reg  <= win_valid;
            m2_valid_reg  <= m1_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("owed result count beyond queue depth");

    a_frame_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (f1_valid_reg || m2_valid_reg) |-> (pending_reg != '0))
        else $error("frame in flight without a queue credit");

    a_tally_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_valid_reg && hit_last_reg) |=> (tally_reg == '0))
        else $error("tally not cleared after frame end");

    a_avg_zero_until_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.window_full) |-> (res.average_cm == '0))
        else $error("mean reported before window full");

endmodule

/* tb/roi_pixel_count_distance_averager_top_tb.sv */
module roi_pixel_count_distance_averager_top_tb;
    import rpcda_pkg::*;

    localparam int WINDOW_FRAMES = 30;
    localparam int CYCLE_LIMIT   = 400000;
    // Covers the pipeline from the closing pixel being taken to its result word, with a little margin on top
    localparam int DRAIN_CYCLES  = 14;
    // Long enough for the 16-deep result queue to fill and pix_ready to drop
    localparam int LONG_HOLD     = 600;
    localparam int PHASE_WORDS   = 285;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_RHYTHM
    } rx_mode_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  pix_valid = 1'b0;
    logic                  pix_ready;
    pix_word_t             pix       = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    res_word_t             res;

    roi_pixel_count_distance_averager_top #(
        .WINDOW_FRAMES(WINDOW_FRAMES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .pix_valid(pix_valid),
        .pix_ready(pix_ready),
        .pix      (pix),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the block: register copies and per-frame state
    // ------------------------------------------------------------------
    logic [7:0]         band_lo      = 8'd50;
    logic [7:0]         band_hi      = 8'd255;
    logic [9:0]         box_left     = 10'd0;
    logic [9:0]         box_top      = 10'd100;
    logic [10:0]        box_cols     = 11'd352;
    logic [10:0]        box_rows     = 11'd300;
    logic signed [20:0] cm_per_pixel = -21'sd2687;
    logic signed [31:0] cm_offset    = 32'sd13998162;

    logic [20:0]        lit_tally  = '0;
    logic signed [15:0] dist_ring [WINDOW_FRAMES];
    int                 ring_fill  = 0;
    int                 ring_slot  = 0;
    longint             ring_total = 0;

    // Pixel words waiting for the driver, and result words owed by the block
    pix_word_t pixel_backlog [$];
    res_word_t frame_results_owed [$];

    int pixels_queued  = 0;
    int pixels_taken   = 0;
    int frames_checked = 0;
    int mismatches     = 0;
    int cycles         = 0;

    // Driver burst/gap bookkeeping
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver stall control
    rx_mode_t rx_mode    = RX_FREE;
    int       mode_left  = 0;
    int       hold_left  = 0;
    logic     hold_req   = 1'b0;
    logic     hold_taken = 1'b0;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH frame %0d: %s", frames_checked, what);
        mismatches++;
    endtask

    // Counts one pixel; on the closing pixel works out the frame's result word
    task automatic account_pixel(input pix_word_t w);
        int        gray;
        bit        in_box;
        longint    q;
        longint    frame_cm;
        longint    mean;
        res_word_t due;
        in_box = int'(w.column) >= int'(box_left) &&
                 int'(w.column) - int'(box_left) < int'(box_cols) &&
                 int'(w.row) >= int'(box_top) &&
                 int'(w.row) - int'(box_top) < int'(box_rows);
        if (in_box)
        begin
            gray = (1868 * int'(w.blue) + 9617 * int'(w.green) +
                    4899 * int'(w.red) + 8192) >>> 14;
            if (gray >= int'(band_lo) && gray <= int'(band_hi) && lit_tally != 21'h1FFFFF)
                lit_tally++;
        end
        if (w.last_of_frame)
        begin
            q = longint'(cm_per_pixel) * longint'(lit_tally) + longint'(cm_offset);
            frame_cm = q / 65536;   // truncates toward zero
            if (frame_cm > 32767)
                frame_cm = 32767;
            if (frame_cm < -32768)
                frame_cm = -32768;
            if (ring_fill >= WINDOW_FRAMES)
                ring_total -= dist_ring[ring_slot];
            else
                ring_fill++;
            dist_ring[ring_slot] = frame_cm[15:0];
            ring_total += frame_cm;
            ring_slot = (ring_slot + 1) % WINDOW_FRAMES;
            mean = (ring_fill >= WINDOW_FRAMES) ? ring_total / WINDOW_FRAMES : 0;
            due.average_cm        = mean[15:0];
            due.frame_distance_cm = frame_cm[15:0];
            due.lit_pixel_count   = lit_tally;
            due.window_full       = ring_fill >= WINDOW_FRAMES;
            frame_results_owed = {frame_results_owed, due};
            lit_tally = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of pixel words with random gaps between them
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid  <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (pix_valid && pix_ready)
            begin
                account_pixel(pix);
                pixels_taken++;
            end
            if (!pix_valid || pix_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left  <= gap_left - 1;
                    pix_valid <= 1'b0;
                end
                else if (pixel_backlog.size() != 0)
                begin
                    pix       <= pixel_backlog.pop_front();
                    pix_valid <= 1'b1;
                    // burst ends on this word: choose the gap and the next burst
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall pattern, redrawn as each run ends; one long
    // hold-off on request so the result queue fills and the input stalls
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready  <= 1'b0;
            rx_mode    <= RX_FREE;
            mode_left  <= 0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
            res_ready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 96);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (rx_mode)
                RX_FREE:   res_ready <= 1'b1;
                RX_COIN:   res_ready <= $urandom_range(0, 1);
                RX_SPARSE: res_ready <= ($urandom_range(0, 3) == 0);
                RX_RHYTHM: res_ready <= (mode_left % 4) != 0;
                default:   res_ready <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result check against the oldest owed word
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        res_word_t due;
        if (rst_n && res_valid && res_ready)
        begin
            if (frame_results_owed.size() == 0)
            begin
                flag_mismatch("result word with no frame pending");
            end
            else
            begin
                due = frame_results_owed.pop_front();
                if (res.average_cm !== due.average_cm)
                    flag_mismatch($sformatf("average_cm %0d, want %0d",
                                            res.average_cm, due.average_cm));
                if (res.frame_distance_cm !== due.frame_distance_cm)
                    flag_mismatch($sformatf("frame_distance_cm %0d, want %0d",
                                            res.frame_distance_cm, due.frame_distance_cm));
                if (res.lit_pixel_count !== due.lit_pixel_count)
                    flag_mismatch($sformatf("lit_pixel_count %0d, want %0d",
                                            res.lit_pixel_count, due.lit_pixel_count));
                if (res.window_full !== due.window_full)
                    flag_mismatch($sformatf("window_full %0b, want %0b",
                                            res.window_full, due.window_full));
            end
            frames_checked++;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_pixel(input int b, input int g, input int r,
                             input int col, input int row, input bit last);
        pix_word_t w;
        w.blue          = 8'(b);
        w.green         = 8'(g);
        w.red           = 8'(r);
        w.column        = 10'(col);
        w.row           = 10'(row);
        w.last_of_frame = last;
        pixel_backlog = {pixel_backlog, w};
        pixels_queued++;
    endtask

    // Registers may only change once every pixel is in and every result out
    task automatic wait_idle();
        while (pixels_taken != pixels_queued || frame_results_owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_LOWER_THR:  band_lo      = value[7:0];
            CFG_UPPER_THR:  band_hi      = value[7:0];
            CFG_ROI_LEFT:   box_left     = value[9:0];
            CFG_ROI_TOP:    box_top      = value[9:0];
            CFG_ROI_WIDTH:  box_cols     = value[10:0];
            CFG_ROI_HEIGHT: box_rows     = value[10:0];
            CFG_SLOPE:      cm_per_pixel = value[20:0];
            CFG_INTERCEPT:  cm_offset    = value;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int lo, input int hi, input int left, input int top,
                                 input int cols, input int rows, input int slope,
                                 input int offset);
        write_reg(CFG_LOWER_THR, 32'(lo));
        write_reg(CFG_UPPER_THR, 32'(hi));
        write_reg(CFG_ROI_LEFT, 32'(left));
        write_reg(CFG_ROI_TOP, 32'(top));
        write_reg(CFG_ROI_WIDTH, 32'(cols));
        write_reg(CFG_ROI_HEIGHT, 32'(rows));
        write_reg(CFG_SLOPE, 32'(slope));
        write_reg(CFG_INTERCEPT, 32'(offset));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random frames, mostly short so the window turns over often. Positions
    // mostly straddle the box edges; a few frames scatter over the whole
    // frame. A third of pixels are flat grey on or just past a threshold.
    task automatic random_phase(input int target);
        int made;
        int len;
        int k;
        int spot;
        int col;
        int row;
        int v;
        int span_c;
        int span_r;
        made = 0;
        while (made < target)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
            spot = $urandom_range(0, 7);
            span_c = ((box_cols > 40) ? 40 : int'(box_cols)) + 4;
            span_r = ((box_rows > 40) ? 40 : int'(box_rows)) + 4;
            for (k = 0; k < len; k++)
            begin
                if (spot == 0)
                begin
                    col = $urandom_range(0, 1023);
                    row = $urandom_range(0, 1023);
                end
                else if (spot < 3)
                begin
                    // far corner of the box
                    col = int'(box_left) + int'(box_cols) - 2 + $urandom_range(0, 3);
                    row = int'(box_top) + int'(box_rows) - 2 + $urandom_range(0, 3);
                end
                else
                begin
                    col = int'(box_left) - 2 + $urandom_range(0, span_c);
                    row = int'(box_top) - 2 + $urandom_range(0, span_r);
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: v = int'(band_lo);
                        1: v = int'(band_hi);
                        2: v = int'(band_lo) - 1;
                        default: v = int'(band_hi) + 1;
                    endcase
                    if (v < 0)
                        v = 0;
                    if (v > 255)
                        v = 255;
                    add_pixel(v, v, v, col, row, k == len - 1);
                end
                else
                begin
                    add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255), col, row, k == len - 1);
                end
            end
            made += len;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin : sequence_main
        int ph;
        int lo;
        int hi;
        foreach (dist_ring[i])
            dist_ring[i] = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: box edges, lower threshold exactly, outside pixels
        add_pixel(255, 255, 255, 0, 100, 1'b0);
        add_pixel(0, 0, 0, 351, 399, 1'b0);
        add_pixel(50, 50, 50, 10, 200, 1'b0);
        add_pixel(49, 49, 49, 10, 200, 1'b0);
        add_pixel(255, 255, 255, 352, 100, 1'b0);
        add_pixel(255, 255, 255, 0, 99, 1'b0);
        add_pixel(255, 255, 255, 0, 400, 1'b1);
        wait_idle();

        // Box in the far corner, past the frame edge; distance saturates high
        apply_setting(0, 0, 1023, 1023, 1024, 1024, 1048575, 32'sh7FFF_FFFF);
        add_pixel(0, 0, 0, 1023, 1023, 1'b0);
        add_pixel(0, 0, 0, 1022, 1023, 1'b0);
        add_pixel(1, 1, 1, 1023, 1022, 1'b0);
        add_pixel(0, 0, 0, 1023, 1023, 1'b1);
        wait_idle();

        // Empty band (lower above upper); most negative distance
        apply_setting(200, 100, 0, 0, 1024, 1024, -1048576, 32'sh8000_0000);
        add_pixel(255, 255, 255, 5, 5, 1'b0);
        add_pixel(150, 150, 150, 6, 5, 1'b1);
        wait_idle();

        // Zero-width box; small negative Q16 value truncates toward zero
        apply_setting(0, 255, 0, 0, 0, 1024, 65536, -65537);
        add_pixel(255, 255, 255, 0, 0, 1'b0);
        add_pixel(255, 255, 255, 1023, 1023, 1'b1);
        wait_idle();

        // One-pixel frame on a one-pixel box, upper threshold exactly
        apply_setting(255, 255, 5, 7, 1, 1, -196608, 65535);
        add_pixel(255, 255, 255, 5, 7, 1'b1);
        wait_idle();

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: apply_setting(50, 255, 0, 100, 352, 300, -2687, 13998162);
                1:
                begin
                    lo = $urandom_range(0, 128);
                    hi = $urandom_range(lo, 255);
                    apply_setting(lo, hi, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                  $urandom_range(1, 64), $urandom_range(1, 64),
                                  int'($urandom_range(0, 600000)) - 300000, $urandom);
                end
                2:
                begin
                    // box hangs over the right and bottom edges
                    lo = $urandom_range(0, 128);
                    hi = $urandom_range(lo, 255);
                    apply_setting(lo, hi, $urandom_range(960, 1023), $urandom_range(960, 1023),
                                  $urandom_range(64, 1024), $urandom_range(64, 1024),
                                  int'($urandom_range(0, 600000)) - 300000, $urandom);
                end
                3:
                begin
                    lo = $urandom_range(1, 255);
                    hi = $urandom_range(0, lo - 1);
                    apply_setting(lo, hi, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                  $urandom_range(1, 1024), $urandom_range(1, 1024),
                                  int'($urandom_range(0, 2097151)) - 1048576, $urandom);
                end
                4: apply_setting(0, 255, 0, 0, 1024, 1024, -1048576, 32'sh7FFF_FFFF);
                default:
                begin
                    lo = $urandom_range(0, 255);
                    hi = $urandom_range(lo, 255);
                    apply_setting(lo, hi, $urandom_range(0, 1023), $urandom_range(0, 1023),
                                  $urandom_range(1, 1024), $urandom_range(1, 1024),
                                  int'($urandom_range(0, 2097151)) - 1048576, $urandom);
                end
            endcase
            if (ph == 1)
            begin
                // receiver goes quiet while this phase's pixels keep coming
                @(posedge clk);
                hold_req <= 1'b1;
            end
            random_phase(PHASE_WORDS);
            wait_idle();
        end

        if (frame_results_owed.size() != 0)
            flag_mismatch("result words still owed at the end");

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
src/rpcda_pkg.sv
src/rpcda_window.sv
src/rpcda_res_fifo.sv
src/roi_pixel_count_distance_averager_top.sv
tb/roi_pixel_count_distance_averager_top_tb.sv
